FILE: rtl/core/flv_pkg.sv
// Shared types, constants and helpers for the FLV H.264 to Annex-B converter.
package flv_pkg;

   // Most transactions one input byte can produce.
   localparam int MAX_EMIT = 5;

   // Tag header and packet type codes.
   localparam logic [3:0] CODEC_AVC  = 4'd7;
   localparam logic [7:0] PKT_CONFIG = 8'd0;
   localparam logic [7:0] PKT_NALU   = 8'd1;

   // Byte counts and indexes inside the headers.
   localparam logic [2:0] CTS_BYTES    = 3'd3;
   localparam logic [2:0] LSIZE_INDEX  = 3'd4;
   localparam logic [2:0] LSIZE_RESET  = 3'd4;
   localparam logic [1:0] START_FINAL  = 2'd3;

   // Parser phases.
   typedef enum logic [3:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PKT_TYPE,
      PH_CTS_CFG,
      PH_CTS_NAL,
      PH_CFG_HDR,
      PH_CFG_NSPS,
      PH_CFG_NPPS,
      PH_CFG_LEN,
      PH_CFG_DATA,
      PH_NAL_LEN,
      PH_NAL_DATA
   } phase_type;

   // One output byte with its framing flags.
   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
      logic       trunc;
   } emit_entry_type;

   // Everything one input byte produces, handed from the parser to the buffer.
   typedef struct packed {
      logic [2:0]                      count;
      emit_entry_type [MAX_EMIT-1:0]   entry;
      logic                            kind;
      logic [3:0]                      frame_type;
      logic [31:0]                     decode_time;
      logic [33:0]                     present_time;
   } emit_batch_type;

   // Byte of the start code 00 00 00 01 at a given position.
   function automatic logic [7:0] start_code_byte(input logic [1:0] idx);
      return (idx == START_FINAL) ? 8'h01 : 8'h00;
   endfunction

endpackage

FILE: rtl/core/flv_parse.sv
// Tag parser: phase tracking, length handling and per-byte output batch.
module flv_parse #(
   parameter int LENGTH_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  logic [7:0]              tag_byte,
   input  logic                    last_of_tag,
   input  logic [31:0]             tag_timestamp,
   output flv_pkg::emit_batch_type batch
);

   flv_pkg::phase_type     phase_ff, phase_in;
   logic [2:0]             len_size_ff, len_size_in;
   logic [2:0]             hdr_idx_ff, hdr_idx_in;
   logic [LENGTH_BITS-1:0] acc_ff, acc_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [7:0]             sets_ff, sets_in;
   logic                   in_pps_ff, in_pps_in;
   logic [3:0]             ftype_ff, ftype_in;
   logic [23:0]            cts_ff, cts_in;
   logic [31:0]            ts_ff, ts_in;
   logic                   hold_valid_ff, hold_valid_in;
   logic [7:0]             hold_byte_ff, hold_byte_in;
   logic                   hold_first_ff, hold_first_in;
   logic                   cfg_started_ff, cfg_started_in;

   // Step decode flags.
   logic [2:0]             push_n;
   logic                   push_start;
   logic                   cfg_fin;
   logic                   clear_hold;
   logic                   set_done;
   logic                   nal_hdr;
   logic                   nal_data;

   // Shared arithmetic.
   logic [2:0]             idx_sum;
   logic [LENGTH_BITS-1:0] acc_sh;
   logic [LENGTH_BITS-1:0] rem_dec;
   logic                   rem_zero;
   logic                   len_zero;
   logic [7:0]             sets_dec;
   logic [15:0]            rem16;

   // Parameter-set stream view: held byte followed by this step's pushes.
   logic [7:0]             slot_byte [flv_pkg::MAX_EMIT];
   logic                   slot_first [flv_pkg::MAX_EMIT];
   logic                   hv;
   logic [2:0]             cnt;
   logic [2:0]             cnt_m1;
   logic                   finish;

   assign idx_sum  = hdr_idx_ff + 3'd1;
   assign acc_sh   = {acc_ff[LENGTH_BITS-9:0], tag_byte};
   assign rem_dec  = rem_ff - LENGTH_BITS'(1);
   assign rem_zero = (rem_dec == '0);
   assign len_zero = (acc_sh == '0);
   assign sets_dec = sets_ff - 8'd1;
   assign rem16    = {acc_ff[7:0], tag_byte};

   // Next phase and next values of the parsing registers.
   always_comb begin
      phase_in   = phase_ff;
      len_size_in = len_size_ff;
      hdr_idx_in = hdr_idx_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      sets_in    = sets_ff;
      in_pps_in  = in_pps_ff;
      ftype_in   = ftype_ff;
      cts_in     = cts_ff;
      ts_in      = ts_ff;
      push_n     = 3'd0;
      push_start = 1'b0;
      cfg_fin    = 1'b0;
      clear_hold = 1'b0;
      set_done   = 1'b0;
      nal_hdr    = 1'b0;
      nal_data   = 1'b0;
      unique case (phase_ff)
         flv_pkg::PH_HEADER: begin
            ftype_in = tag_byte[7:4];
            ts_in    = tag_timestamp;
            phase_in = (tag_byte[3:0] == flv_pkg::CODEC_AVC) ? flv_pkg::PH_PKT_TYPE
                                                             : flv_pkg::PH_SKIP;
         end
         flv_pkg::PH_SKIP: begin
         end
         flv_pkg::PH_PKT_TYPE: begin
            hdr_idx_in = 3'd0;
            cts_in     = 24'd0;
            if (tag_byte == flv_pkg::PKT_CONFIG) begin
               phase_in = flv_pkg::PH_CTS_CFG;
            end else if (tag_byte == flv_pkg::PKT_NALU) begin
               phase_in = flv_pkg::PH_CTS_NAL;
            end else begin
               phase_in = flv_pkg::PH_SKIP;
            end
         end
         flv_pkg::PH_CTS_CFG, flv_pkg::PH_CTS_NAL: begin
            cts_in = {cts_ff[15:0], tag_byte};
            if (idx_sum >= flv_pkg::CTS_BYTES) begin
               hdr_idx_in = 3'd0;
               acc_in     = '0;
               if (phase_ff == flv_pkg::PH_CTS_CFG) begin
                  clear_hold = 1'b1;
                  phase_in   = flv_pkg::PH_CFG_HDR;
               end else begin
                  phase_in = flv_pkg::PH_NAL_LEN;
               end
            end else begin
               hdr_idx_in = idx_sum;
            end
         end
         flv_pkg::PH_CFG_HDR: begin
            if (hdr_idx_ff == flv_pkg::LSIZE_INDEX) begin
               len_size_in = {1'b0, tag_byte[1:0]} + 3'd1;
               phase_in    = flv_pkg::PH_CFG_NSPS;
            end
            hdr_idx_in = idx_sum;
         end
         flv_pkg::PH_CFG_NSPS: begin
            sets_in    = {3'b000, tag_byte[4:0]};
            in_pps_in  = 1'b0;
            hdr_idx_in = 3'd0;
            phase_in   = (tag_byte[4:0] == 5'd0) ? flv_pkg::PH_CFG_NPPS
                                                 : flv_pkg::PH_CFG_LEN;
         end
         flv_pkg::PH_CFG_NPPS: begin
            sets_in    = tag_byte;
            in_pps_in  = 1'b1;
            hdr_idx_in = 3'd0;
            if (tag_byte == 8'd0) begin
               cfg_fin  = 1'b1;
               phase_in = flv_pkg::PH_SKIP;
            end else begin
               phase_in = flv_pkg::PH_CFG_LEN;
            end
         end
         flv_pkg::PH_CFG_LEN: begin
            if (hdr_idx_ff == 3'd0) begin
               acc_in     = LENGTH_BITS'(tag_byte);
               hdr_idx_in = 3'd1;
            end else begin
               rem_in     = LENGTH_BITS'(rem16);
               push_n     = 3'd4;
               push_start = 1'b1;
               if (rem16 == 16'd0) begin
                  set_done = 1'b1;
               end else begin
                  phase_in = flv_pkg::PH_CFG_DATA;
               end
            end
         end
         flv_pkg::PH_CFG_DATA: begin
            push_n = 3'd1;
            rem_in = rem_dec;
            if (rem_zero) begin
               set_done = 1'b1;
            end
         end
         flv_pkg::PH_NAL_LEN: begin
            if (idx_sum >= len_size_ff) begin
               nal_hdr    = 1'b1;
               rem_in     = acc_sh;
               hdr_idx_in = 3'd0;
               acc_in     = '0;
               phase_in   = len_zero ? flv_pkg::PH_NAL_LEN : flv_pkg::PH_NAL_DATA;
            end else begin
               acc_in     = acc_sh;
               hdr_idx_in = idx_sum;
            end
         end
         flv_pkg::PH_NAL_DATA: begin
            nal_data = 1'b1;
            rem_in   = rem_dec;
            if (rem_zero) begin
               phase_in = flv_pkg::PH_NAL_LEN;
            end
         end
         default: begin
         end
      endcase

      // End of one parameter set: next set, picture sets, or record done.
      if (set_done) begin
         sets_in    = sets_dec;
         hdr_idx_in = 3'd0;
         if (sets_dec != 8'd0) begin
            phase_in = flv_pkg::PH_CFG_LEN;
         end else if (!in_pps_ff) begin
            phase_in = flv_pkg::PH_CFG_NPPS;
         end else begin
            cfg_fin  = 1'b1;
            phase_in = flv_pkg::PH_SKIP;
         end
      end

      // The final byte of a tag always returns to the tag header.
      if (last_of_tag) begin
         phase_in   = flv_pkg::PH_HEADER;
         hdr_idx_in = 3'd0;
         acc_in     = '0;
      end
   end

   // Line up the held parameter-set byte with the bytes pushed in this step.
   always_comb begin
      hv = hold_valid_ff && !clear_hold;
      for (int k = 0; k < flv_pkg::MAX_EMIT; k++) begin
         if (hv && (k == 0)) begin
            slot_byte[k]  = hold_byte_ff;
            slot_first[k] = hold_first_ff;
         end else begin
            slot_byte[k]  = push_start ? flv_pkg::start_code_byte(2'(hv ? k - 1 : k))
                                       : tag_byte;
            slot_first[k] = ((hv ? k - 1 : k) == 0) && !cfg_started_ff;
         end
      end
   end

   assign cnt    = 3'(hv) + push_n;
   assign cnt_m1 = cnt - 3'd1;
   assign finish = cfg_fin || last_of_tag;

   // Output batch and next state of the hold register.
   always_comb begin
      batch              = '0;
      batch.frame_type   = ftype_ff;
      batch.decode_time  = ts_ff;
      batch.present_time = {2'b00, ts_ff} + {{10{cts_ff[23]}}, cts_ff};
      hold_valid_in      = (cnt != 3'd0) && !finish;
      hold_byte_in       = hold_byte_ff;
      hold_first_in      = hold_first_ff;
      cfg_started_in     = clear_hold ? 1'b0 : (cfg_started_ff || (push_n != 3'd0));
      if (cnt != 3'd0) begin
         hold_byte_in  = slot_byte[cnt_m1];
         hold_first_in = slot_first[cnt_m1];
      end
      if (nal_hdr) begin
         batch.kind  = 1'b1;
         batch.count = 3'd4;
         for (int k = 0; k < 4; k++) begin
            batch.entry[k].data  = flv_pkg::start_code_byte(2'(k));
            batch.entry[k].first = (k == 0);
            batch.entry[k].last  = (k == 3) && (len_zero || last_of_tag);
            batch.entry[k].trunc = (k == 3) && !len_zero && last_of_tag;
         end
      end else if (nal_data) begin
         batch.kind           = 1'b1;
         batch.count          = 3'd1;
         batch.entry[0].data  = tag_byte;
         batch.entry[0].first = 1'b0;
         batch.entry[0].last  = rem_zero || last_of_tag;
         batch.entry[0].trunc = !rem_zero && last_of_tag;
      end else begin
         batch.kind  = 1'b0;
         batch.count = finish ? cnt : ((cnt == 3'd0) ? 3'd0 : cnt_m1);
         for (int k = 0; k < flv_pkg::MAX_EMIT; k++) begin
            batch.entry[k].data  = slot_byte[k];
            batch.entry[k].first = slot_first[k];
            batch.entry[k].last  = finish && (3'(k) == cnt_m1);
            batch.entry[k].trunc = finish && (3'(k) == cnt_m1) && !cfg_fin;
         end
      end
   end

   // Parser registers advance on every accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= flv_pkg::PH_HEADER;
         len_size_ff    <= flv_pkg::LSIZE_RESET;
         hdr_idx_ff     <= 3'd0;
         acc_ff         <= '0;
         rem_ff         <= '0;
         sets_ff        <= 8'd0;
         in_pps_ff      <= 1'b0;
         ftype_ff       <= 4'd0;
         cts_ff         <= 24'd0;
         ts_ff          <= 32'd0;
         hold_valid_ff  <= 1'b0;
         hold_byte_ff   <= 8'd0;
         hold_first_ff  <= 1'b0;
         cfg_started_ff <= 1'b0;
      end else if (take) begin
         phase_ff       <= phase_in;
         len_size_ff    <= len_size_in;
         hdr_idx_ff     <= hdr_idx_in;
         acc_ff         <= acc_in;
         rem_ff         <= rem_in;
         sets_ff        <= sets_in;
         in_pps_ff      <= in_pps_in;
         ftype_ff       <= ftype_in;
         cts_ff         <= cts_in;
         ts_ff          <= ts_in;
         hold_valid_ff  <= hold_valid_in;
         hold_byte_ff   <= hold_byte_in;
         hold_first_ff  <= hold_first_in;
         cfg_started_ff <= cfg_started_in;
      end
   end

   // A held byte exists only while a configuration record is being parsed.
   a_hold_in_cfg: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (phase_ff == flv_pkg::PH_CFG_NSPS || phase_ff == flv_pkg::PH_CFG_NPPS ||
                         phase_ff == flv_pkg::PH_CFG_LEN || phase_ff == flv_pkg::PH_CFG_DATA))
      else $error("held parameter-set byte outside a configuration record");

   // The length size always stays between one and four bytes.
   a_len_size: assert property (@(posedge clock) disable iff (reset)
      (len_size_ff != 3'd0) && (len_size_ff <= flv_pkg::LSIZE_RESET))
      else $error("length size out of range");

   // The header index never runs past the length-size byte of the record; it sits
   // one higher only while the set count byte that follows is parsed.
   a_hdr_idx: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == flv_pkg::PH_CFG_NSPS) || (hdr_idx_ff <= flv_pkg::LSIZE_INDEX))
      else $error("header index out of range");

   // The final byte of a tag always leads back to the tag header.
   a_tag_end: assert property (@(posedge clock) disable iff (reset)
      take && last_of_tag |=> (phase_ff == flv_pkg::PH_HEADER) && !hold_valid_ff)
      else $error("tag end did not return to the header phase");

endmodule

FILE: rtl/core/flv_obuf.sv
// Result buffer: holds one batch of output bytes and shifts them out in order.
module flv_obuf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  flv_pkg::emit_batch_type batch,
   output logic                    busy,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_unit_kind,
   output logic [3:0]              rsp_frame_type,
   output logic                    rsp_unit_first,
   output logic                    rsp_unit_last,
   output logic [31:0]             rsp_decode_time,
   output logic signed [33:0]      rsp_present_time,
   output logic                    rsp_truncated
);

   logic [2:0]                                   count_ff, count_in;
   flv_pkg::emit_entry_type [flv_pkg::MAX_EMIT-1:0] entry_ff, entry_in;
   logic                                         kind_ff;
   logic [3:0]                                   ftype_ff;
   logic [31:0]                                  dts_ff;
   logic [33:0]                                  pts_ff;
   logic                                         drain;

   assign drain = (count_ff != 3'd0) && !rsp_stall;

   // The input side waits while more than the departing transaction remains.
   assign busy = (count_ff > 3'd1) || ((count_ff == 3'd1) && rsp_stall);

   // Load a new batch or shift the remaining entries toward the head.
   always_comb begin
      count_in = count_ff;
      entry_in = entry_ff;
      if (load) begin
         count_in = batch.count;
         entry_in = batch.entry;
      end else if (drain) begin
         count_in = count_ff - 3'd1;
         for (int i = 0; i < flv_pkg::MAX_EMIT - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
      end
   end

   // Count is control state; entries and unit fields are payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (load) begin
         kind_ff  <= batch.kind;
         ftype_ff <= batch.frame_type;
         dts_ff   <= batch.decode_time;
         pts_ff   <= batch.present_time;
      end
   end

   // The head entry drives the result channel.
   assign rsp_valid        = (count_ff != 3'd0);
   assign rsp_out_byte     = entry_ff[0].data;
   assign rsp_unit_first   = entry_ff[0].first;
   assign rsp_unit_last    = entry_ff[0].last;
   assign rsp_truncated    = entry_ff[0].trunc;
   assign rsp_unit_kind    = kind_ff;
   assign rsp_frame_type   = ftype_ff;
   assign rsp_decode_time  = dts_ff;
   assign rsp_present_time = $signed(pts_ff);

   // The buffer never holds more than one full batch.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(flv_pkg::MAX_EMIT))
      else $error("result buffer overfilled");

   // A loaded batch with bytes shows a result in the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load && (batch.count != 3'd0) |=> rsp_valid)
      else $error("loaded batch not presented");

   // A stalled result keeps the whole batch in place.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(count_ff))
      else $error("buffer count moved under stall");

   // An empty buffer never holds off the input side.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !busy)
      else $error("empty buffer stalled the input");

endmodule

FILE: rtl/core/flv_avc_to_annexb_converter_top.sv
// Top level of the FLV H.264 video tag to Annex-B byte stream converter.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  tag_byte, last_of_tag, tag_timestamp
//   rsp_      out        rsp_valid/rsp_stall  out_byte, unit_kind, frame_type,
//                                             unit_first, unit_last, decode_time,
//                                             present_time, truncated
//
// Each accepted byte is parsed combinationally; its zero to five output transactions
// are loaded into a shift buffer that delivers one per cycle while rsp_stall is low,
// and a new byte is taken only when at most the departing transaction remains.
// Reset is synchronous; no clearing pass follows. rsp_stall holds the head result
// and, while only that transaction remains, propagates to req_stall in the same cycle.
module flv_avc_to_annexb_converter_top #(
   parameter int LENGTH_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_tag_byte,
   input  logic               req_last_of_tag,
   input  logic [31:0]        req_tag_timestamp,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_unit_kind,
   output logic [3:0]         rsp_frame_type,
   output logic               rsp_unit_first,
   output logic               rsp_unit_last,
   output logic [31:0]        rsp_decode_time,
   output logic signed [33:0] rsp_present_time,
   output logic               rsp_truncated
);

   logic                    take;
   logic                    busy;
   flv_pkg::emit_batch_type batch;

   // An input transaction completes when valid meets a free buffer.
   assign take      = req_valid && !busy;
   assign req_stall = busy;

   flv_parse #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .tag_byte     (req_tag_byte),
      .last_of_tag  (req_last_of_tag),
      .tag_timestamp(req_tag_timestamp),
      .batch        (batch)
   );

   flv_obuf u_obuf (
      .clock           (clock),
      .reset           (reset),
      .load            (take),
      .batch           (batch),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_unit_kind   (rsp_unit_kind),
      .rsp_frame_type  (rsp_frame_type),
      .rsp_unit_first  (rsp_unit_first),
      .rsp_unit_last   (rsp_unit_last),
      .rsp_decode_time (rsp_decode_time),
      .rsp_present_time(rsp_present_time),
      .rsp_truncated   (rsp_truncated)
   );

endmodule

FILE: tb/sv/flv_avc_to_annexb_converter_top_tb.sv
// Self-checking testbench for the FLV H.264 tag to Annex-B byte stream converter.
module flv_avc_to_annexb_converter_top_tb;

   localparam int NAL_LEN_BITS = 32;
   localparam logic [63:0] NAL_LEN_SPAN = (64'd1 << NAL_LEN_BITS) - 64'd1;
   localparam logic [31:0] START_CODE = 32'h0000_0001;
   localparam int DRAIN_CYCLES = 8;

   // Kinds of unit on the output side.
   localparam logic KIND_PARAM_SETS = 1'b0;
   localparam logic KIND_NAL_UNIT   = 1'b1;

   // Kinds of tag made by the random traffic generator.
   typedef enum int {
      GEN_NALU,
      GEN_CONFIG,
      GEN_OTHER_CODEC,
      GEN_NOISE
   } tag_shape_type;

   // One expected Annex-B output transaction.
   typedef struct {
      logic [7:0]  out_byte;
      logic        kind;
      logic [3:0]  frame_type;
      logic        unit_first;
      logic        unit_last;
      logic [31:0] decode_time;
      logic [33:0] present_time;
      logic        truncated;
   } annexb_byte_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_tag_byte;
   logic               req_last_of_tag;
   logic [31:0]        req_tag_timestamp;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [7:0]         rsp_out_byte;
   logic               rsp_unit_kind;
   logic [3:0]         rsp_frame_type;
   logic               rsp_unit_first;
   logic               rsp_unit_last;
   logic [31:0]        rsp_decode_time;
   logic signed [33:0] rsp_present_time;
   logic               rsp_truncated;

   // Parser state mirrored by the predictor.
   flv_pkg::phase_type parse_phase;
   logic [2:0]  len_size;
   logic [2:0]  hdr_idx;
   logic [31:0] len_acc;
   logic [31:0] bytes_left;
   logic [7:0]  sets_left;
   logic        in_pps;
   logic [3:0]  frame_nibble;
   logic [23:0] cts_offset;
   logic [31:0] tag_ts;
   logic        held_valid;
   logic [7:0]  held_byte;
   logic        held_first;
   logic        unit_open;
   int          emitted_now;

   annexb_byte_type pending_annexb[$];
   logic [7:0]      tag_body[$];
   int              errors;
   int              items_sent;
   bit              idling_on;

   flv_avc_to_annexb_converter_top #(
      .LENGTH_BITS(NAL_LEN_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_tag_byte(req_tag_byte),
      .req_last_of_tag(req_last_of_tag),
      .req_tag_timestamp(req_tag_timestamp),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_unit_kind(rsp_unit_kind),
      .rsp_frame_type(rsp_frame_type),
      .rsp_unit_first(rsp_unit_first),
      .rsp_unit_last(rsp_unit_last),
      .rsp_decode_time(rsp_decode_time),
      .rsp_present_time(rsp_present_time),
      .rsp_truncated(rsp_truncated)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Safety net against a hung handshake.
   initial begin
      #6_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Queues one expected transaction, at most MAX_EMIT per input byte.
   function automatic void push_annexb(input logic [7:0] b, input logic kind,
                                       input logic first, input logic fin,
                                       input logic trunc);
      annexb_byte_type e;
      if (emitted_now >= flv_pkg::MAX_EMIT) return;
      e.out_byte     = b;
      e.kind         = kind;
      e.frame_type   = frame_nibble;
      e.unit_first   = first;
      e.unit_last    = fin;
      e.decode_time  = tag_ts;
      e.present_time = {2'b00, tag_ts} + {{10{cts_offset[23]}}, cts_offset};
      e.truncated    = trunc;
      pending_annexb.push_back(e);
      emitted_now++;
   endfunction

   // The parameter set unit is delayed by one byte so that its end can be flagged.
   function automatic void hold_param_byte(input logic [7:0] b);
      if (held_valid) push_annexb(held_byte, KIND_PARAM_SETS, held_first, 1'b0, 1'b0);
      held_valid = 1'b1;
      held_byte  = b;
      held_first = !unit_open;
      unit_open  = 1'b1;
   endfunction

   function automatic void close_param_unit(input logic trunc);
      if (held_valid) push_annexb(held_byte, KIND_PARAM_SETS, held_first, 1'b1, trunc);
      held_valid = 1'b0;
   endfunction

   function automatic void param_set_done();
      sets_left = sets_left - 8'd1;
      hdr_idx   = '0;
      if (sets_left != 8'd0) begin
         parse_phase = flv_pkg::PH_CFG_LEN;
      end else if (!in_pps) begin
         parse_phase = flv_pkg::PH_CFG_NPPS;
      end else begin
         close_param_unit(1'b0);
         parse_phase = flv_pkg::PH_SKIP;
      end
   endfunction

   function automatic void reset_parser();
      parse_phase  = flv_pkg::PH_HEADER;
      len_size     = flv_pkg::LSIZE_RESET;
      hdr_idx      = '0;
      len_acc      = '0;
      bytes_left   = '0;
      sets_left    = '0;
      in_pps       = 1'b0;
      frame_nibble = '0;
      cts_offset   = '0;
      tag_ts       = '0;
      held_valid   = 1'b0;
      held_byte    = '0;
      held_first   = 1'b0;
      unit_open    = 1'b0;
   endfunction

   // Advances the parser by one tag byte and queues the Annex-B bytes it yields.
   function automatic void predict_annexb(input logic [7:0] b, input logic fin,
                                          input logic [31:0] ts);
      logic [31:0] nal_len;
      int i;
      emitted_now = 0;
      case (parse_phase)
         flv_pkg::PH_HEADER: begin
            frame_nibble = b[7:4];
            tag_ts       = ts;
            parse_phase  = (b[3:0] == flv_pkg::CODEC_AVC) ? flv_pkg::PH_PKT_TYPE
                                                          : flv_pkg::PH_SKIP;
         end
         flv_pkg::PH_PKT_TYPE: begin
            hdr_idx    = '0;
            cts_offset = '0;
            if (b == flv_pkg::PKT_CONFIG) parse_phase = flv_pkg::PH_CTS_CFG;
            else if (b == flv_pkg::PKT_NALU) parse_phase = flv_pkg::PH_CTS_NAL;
            else parse_phase = flv_pkg::PH_SKIP;
         end
         flv_pkg::PH_CTS_CFG, flv_pkg::PH_CTS_NAL: begin
            cts_offset = {cts_offset[15:0], b};
            hdr_idx    = hdr_idx + 3'd1;
            if (hdr_idx >= flv_pkg::CTS_BYTES) begin
               hdr_idx = '0;
               len_acc = '0;
               if (parse_phase == flv_pkg::PH_CTS_CFG) begin
                  held_valid  = 1'b0;
                  unit_open   = 1'b0;
                  parse_phase = flv_pkg::PH_CFG_HDR;
               end else begin
                  parse_phase = flv_pkg::PH_NAL_LEN;
               end
            end
         end
         flv_pkg::PH_CFG_HDR: begin
            if (hdr_idx == flv_pkg::LSIZE_INDEX) begin
               len_size    = {1'b0, b[1:0]} + 3'd1;
               parse_phase = flv_pkg::PH_CFG_NSPS;
            end
            hdr_idx = hdr_idx + 3'd1;
         end
         flv_pkg::PH_CFG_NSPS: begin
            sets_left   = {3'b000, b[4:0]};
            in_pps      = 1'b0;
            hdr_idx     = '0;
            parse_phase = (sets_left == 8'd0) ? flv_pkg::PH_CFG_NPPS : flv_pkg::PH_CFG_LEN;
         end
         flv_pkg::PH_CFG_NPPS: begin
            sets_left = b;
            in_pps    = 1'b1;
            hdr_idx   = '0;
            if (sets_left == 8'd0) begin
               close_param_unit(1'b0);
               parse_phase = flv_pkg::PH_SKIP;
            end else begin
               parse_phase = flv_pkg::PH_CFG_LEN;
            end
         end
         flv_pkg::PH_CFG_LEN: begin
            if (hdr_idx == 3'd0) begin
               len_acc = {24'd0, b};
               hdr_idx = 3'd1;
            end else begin
               bytes_left = {16'd0, len_acc[7:0], b};
               for (i = 0; i < 4; i++) hold_param_byte(START_CODE[8*(3-i) +: 8]);
               if (bytes_left == 32'd0) param_set_done();
               else parse_phase = flv_pkg::PH_CFG_DATA;
            end
         end
         flv_pkg::PH_CFG_DATA: begin
            hold_param_byte(b);
            bytes_left = bytes_left - 32'd1;
            if (bytes_left == 32'd0) param_set_done();
         end
         flv_pkg::PH_NAL_LEN: begin
            len_acc = {len_acc[23:0], b};
            hdr_idx = hdr_idx + 3'd1;
            if (hdr_idx >= len_size) begin
               nal_len = len_acc & NAL_LEN_SPAN[31:0];
               for (i = 0; i < 4; i++) begin
                  push_annexb(START_CODE[8*(3-i) +: 8], KIND_NAL_UNIT, i == 0,
                              (i == 3) && (nal_len == 32'd0 || fin),
                              (i == 3) && nal_len != 32'd0 && fin);
               end
               bytes_left  = nal_len;
               hdr_idx     = '0;
               len_acc     = '0;
               parse_phase = (nal_len == 32'd0) ? flv_pkg::PH_NAL_LEN : flv_pkg::PH_NAL_DATA;
            end
         end
         flv_pkg::PH_NAL_DATA: begin
            bytes_left = bytes_left - 32'd1;
            if (bytes_left == 32'd0) begin
               push_annexb(b, KIND_NAL_UNIT, 1'b0, 1'b1, 1'b0);
               parse_phase = flv_pkg::PH_NAL_LEN;
            end else begin
               push_annexb(b, KIND_NAL_UNIT, 1'b0, fin, fin);
            end
         end
         default: begin
         end
      endcase

      // The end of a tag closes any open parameter set unit and resyncs on a header.
      if (fin) begin
         close_param_unit(1'b1);
         parse_phase = flv_pkg::PH_HEADER;
         hdr_idx     = '0;
         len_acc     = '0;
      end
   endfunction

   function automatic void check_field(input string name, input logic [33:0] want,
                                       input logic [33:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Prediction on accepted input and comparison on accepted output.
   always @(posedge clock) begin
      annexb_byte_type want;
      if (!reset) begin
         if (req_valid && !req_stall) predict_annexb(req_tag_byte, req_last_of_tag,
                                                     req_tag_timestamp);
         if (rsp_valid && !rsp_stall) begin
            if (pending_annexb.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual byte %h",
                        $time, rsp_out_byte);
               errors++;
            end else begin
               want = pending_annexb.pop_front();
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("unit_kind", want.kind, rsp_unit_kind);
               check_field("frame_type", want.frame_type, rsp_frame_type);
               check_field("unit_first", want.unit_first, rsp_unit_first);
               check_field("unit_last", want.unit_last, rsp_unit_last);
               check_field("decode_time", want.decode_time, rsp_decode_time);
               check_field("present_time", want.present_time, rsp_present_time);
               check_field("truncated", want.truncated, rsp_truncated);
            end
         end
      end
   end

   // Receiver stalls: random bursts separated by quiet stretches.
   initial begin
      int stall_left;
      int quiet_left;
      stall_left = 0;
      quiet_left = 0;
      forever begin
         @(negedge clock);
         if (!idling_on) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (quiet_left > 0) begin
            quiet_left--;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_stall <= 1'b1;
         end else begin
            quiet_left = $urandom_range(0, 30);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Sends one tag byte; entered and left at a falling edge.
   task automatic send_tag_byte(input logic [7:0] b, input logic fin,
                                input logic [31:0] ts);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_tag_byte      <= b;
      req_last_of_tag   <= fin;
      req_tag_timestamp <= ts;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Sends the whole of tag_body, the header byte carrying the tag timestamp.
   task automatic send_tag(input logic [31:0] hdr_ts);
      int k;
      for (k = 0; k < tag_body.size(); k++) begin
         send_tag_byte(tag_body[k], k == tag_body.size() - 1, (k == 0) ? hdr_ts : $urandom());
      end
   endtask

   // Holds the sender off until every expected transaction has arrived.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_annexb.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // A one-byte tag with a foreign codec and an all-ones timestamp.
   task automatic test_non_avc_tag();
      tag_body = '{8'hF2};
      send_tag(32'hFFFF_FFFF);
   endtask

   // An H.264 tag with a packet type that is neither record nor NAL units.
   task automatic test_unknown_packet();
      tag_body = '{8'h17, 8'hFF, 8'h00};
      send_tag(32'h0000_0000);
   endtask

   // A record with one SPS and an empty PPS, length size 1, then trailing bytes.
   task automatic test_config_record();
      tag_body = '{8'h07, flv_pkg::PKT_CONFIG, 8'h00, 8'h00, 8'h00,
                   8'h01, 8'h64, 8'h00, 8'h1F, 8'hFC,
                   8'hE1, 8'h00, 8'h02, 8'h67, 8'h42,
                   8'h01, 8'h00, 8'h00, 8'hAA};
      send_tag(32'h8000_0000);
   endtask

   // Negative offset at time zero; an empty unit, a full unit, a cut-off unit.
   task automatic test_nalu_units();
      tag_body = '{8'h17, flv_pkg::PKT_NALU, 8'hFF, 8'hFF, 8'hFF,
                   8'h00, 8'h02, 8'hAB, 8'hCD, 8'h05, 8'h11};
      send_tag(32'h0000_0000);
   endtask

   // Random tags, mostly well-formed, until the byte count reaches the target.
   task automatic test_random_traffic(input int target);
      tag_shape_type shape;
      logic [3:0]  frame;
      logic [3:0]  codec;
      logic [31:0] len;
      int pick, units, n, k, s, sets, keep;
      bit big, cut;
      while (items_sent < target) begin
         tag_body.delete();
         frame = $urandom_range(0, 15);
         pick  = $urandom_range(0, 9);
         shape = (pick <= 5) ? GEN_NALU : (pick <= 7) ? GEN_CONFIG :
                 (pick == 8) ? GEN_OTHER_CODEC : GEN_NOISE;
         big   = 1'b0;
         case (shape)
            GEN_NALU: begin
               tag_body.push_back({frame, flv_pkg::CODEC_AVC});
               tag_body.push_back(flv_pkg::PKT_NALU);
               repeat (3) tag_body.push_back($urandom());
               units = $urandom_range(0, 3);
               for (k = 0; k < units && !big; k++) begin
                  len = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 10);
                  if (len_size < 3'd4) len = len & ((32'd1 << (8 * len_size)) - 32'd1);
                  for (s = len_size - 1; s >= 0; s--) tag_body.push_back(len[8*s +: 8]);
                  big = len > 32'd16;
                  n = big ? $urandom_range(0, 16) : len;
                  repeat (n) tag_body.push_back($urandom());
               end
            end
            GEN_CONFIG: begin
               tag_body.push_back({frame, flv_pkg::CODEC_AVC});
               tag_body.push_back(flv_pkg::PKT_CONFIG);
               repeat (3) tag_body.push_back($urandom());
               repeat (5) tag_body.push_back($urandom());
               big  = $urandom_range(0, 19) == 0;
               sets = big ? 31 : $urandom_range(0, 2);
               tag_body.push_back({3'($urandom_range(0, 7)), 5'(sets)});
               for (s = 0; s < 2; s++) begin
                  if (s == 1) begin
                     sets = $urandom_range(0, 2);
                     tag_body.push_back(8'(sets));
                  end
                  repeat (sets) begin
                     len = big ? $urandom_range(0, 2) : $urandom_range(0, 6);
                     tag_body.push_back(len[15:8]);
                     tag_body.push_back(len[7:0]);
                     repeat (len) tag_body.push_back($urandom());
                  end
               end
               repeat ($urandom_range(0, 3)) tag_body.push_back($urandom());
            end
            GEN_OTHER_CODEC: begin
               codec = $urandom_range(0, 14);
               if (codec >= flv_pkg::CODEC_AVC) codec = codec + 4'd1;
               tag_body.push_back({frame, codec});
               repeat ($urandom_range(0, 4)) tag_body.push_back($urandom());
            end
            default: begin
               repeat ($urandom_range(1, 8)) tag_body.push_back($urandom());
            end
         endcase
         // Cut some tags short so that every field and unit can end early.
         cut = big || ($urandom_range(0, 4) == 0);
         if (cut) begin
            keep = $urandom_range(1, tag_body.size());
            while (tag_body.size() > keep) void'(tag_body.pop_back());
         end
         send_tag($urandom());
      end
   endtask

   // Final stretch with both sides running flat out.
   task automatic test_steady_tail(input int target);
      idling_on = 1'b0;
      test_random_traffic(target);
   endtask

   // Test sequence.
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_tag_byte      = '0;
      req_last_of_tag   = 1'b0;
      req_tag_timestamp = '0;
      rsp_stall         = 1'b0;
      idling_on         = 1'b1;
      errors            = 0;
      items_sent        = 0;
      reset_parser();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_non_avc_tag();
      test_unknown_packet();
      test_config_record();
      test_nalu_units();
      wait_for_drain();
      test_random_traffic(180);
      wait_for_drain();
      test_random_traffic(300);
      test_steady_tail(350);

      // Let the last results come out, then look for stray extra transactions.
      wait_for_drain();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
